@@ design/ami_pkg.sv @@
// ----------------------------------------------------------------------------
// ami_pkg
// Shared types, command codes and constant tables for the affine matrix
// inverse block.
// ----------------------------------------------------------------------------
package ami_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OPND_W = 33;
   localparam int unsigned PROD_W = 66;
   localparam int unsigned COF_W  = 65;
   localparam int unsigned DET_W  = 97;
   localparam int unsigned MAG_W  = 96;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_WRITE,
      OP_LDA_M,
      OP_LDB_M,
      OP_LDA_COF,
      OP_LDA_RES,
      OP_MUL,
      OP_ACC_COF,
      OP_ACC_DET,
      OP_ACC_TRN,
      OP_TRN_STORE,
      OP_DIV_START,
      OP_DIV_STORE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] maddr;
      logic [3:0] cidx;
      logic [3:0] ridx;
      logic       neg;
      logic       first;
      logic       hi;
   } cmd_type;

   typedef struct packed {
      logic singular;
      logic div_busy;
      logic out_free;
   } sts_type;

   // Store addresses of the cofactor a*b - c*d; part selects (a,b) or (c,d).
   function automatic logic [3:0] cof_addr(input logic [3:0] k, input logic part,
                                           input logic second);
      logic [15:0] q;
      logic [7:0]  pair;
      begin
         case (k)
            4'd0:    q = {4'd5, 4'd10, 4'd6, 4'd9};
            4'd1:    q = {4'd9, 4'd2, 4'd10, 4'd1};
            4'd2:    q = {4'd1, 4'd6, 4'd2, 4'd5};
            4'd3:    q = {4'd6, 4'd8, 4'd4, 4'd10};
            4'd4:    q = {4'd10, 4'd0, 4'd8, 4'd2};
            4'd5:    q = {4'd2, 4'd4, 4'd0, 4'd6};
            4'd6:    q = {4'd4, 4'd9, 4'd5, 4'd8};
            4'd7:    q = {4'd8, 4'd1, 4'd9, 4'd0};
            4'd8:    q = {4'd0, 4'd5, 4'd1, 4'd4};
            default: q = '0;
         endcase
         pair = part ? q[7:0] : q[15:8];
         return second ? pair[3:0] : pair[7:4];
      end
   endfunction

   // Row-major position of the k-th element of the 3x3 block.
   function automatic logic [3:0] blk_pos(input logic [3:0] k);
      begin
         case (k)
            4'd0:    return 4'd0;
            4'd1:    return 4'd1;
            4'd2:    return 4'd2;
            4'd3:    return 4'd4;
            4'd4:    return 4'd5;
            4'd5:    return 4'd6;
            4'd6:    return 4'd8;
            4'd7:    return 4'd9;
            4'd8:    return 4'd10;
            default: return 4'd0;
         endcase
      end
   endfunction

   // Signs a magnitude and clamps it to 32 bits; the top bit flags a clamp.
   function automatic logic [32:0] sat32(input logic over, input logic [31:0] mag,
                                         input logic neg);
      logic clamp;
      begin
         if (neg) begin
            clamp = over | (mag[31] & (|mag[30:0]));
         end else begin
            clamp = over | mag[31];
         end
         if (clamp) begin
            return {1'b1, (neg ? 32'h8000_0000 : 32'h7FFF_FFFF)};
         end
         return {1'b0, (neg ? (~mag + 32'd1) : mag)};
      end
   endfunction

endpackage

@@ design/ami_div.sv @@
// ----------------------------------------------------------------------------
// ami_div
// Bit-serial restoring divider: one quotient bit per cycle over a 96-bit
// dividend, keeping the low 32 quotient bits and an overflow flag.
// ----------------------------------------------------------------------------
module ami_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num_mag,
   input  logic [95:0] den_mag,
   input  logic        neg,
   output logic        busy,
   output logic        over,
   output logic [31:0] quot,
   output logic        quot_neg
);

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff;
   logic [95:0] rem_ff;
   logic [95:0] num_ff;
   logic [95:0] den_ff;
   logic [31:0] q_ff;
   logic        over_ff;
   logic        neg_ff;

   logic [96:0] trial;
   logic        qbit;
   logic [96:0] diff;

   always_comb begin
      trial = {rem_ff, num_ff[95]};
      qbit  = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && (cnt_ff == 7'd95)) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= '0;
         rem_ff  <= '0;
         num_ff  <= {num_mag, 32'd0};
         den_ff  <= den_mag;
         q_ff    <= '0;
         over_ff <= 1'b0;
         neg_ff  <= neg;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + 7'd1;
         rem_ff  <= qbit ? diff[95:0] : trial[95:0];
         num_ff  <= {num_ff[94:0], 1'b0};
         q_ff    <= {q_ff[30:0], qbit};
         over_ff <= over_ff | q_ff[31];
      end
   end

   assign busy     = busy_ff;
   assign over     = over_ff;
   assign quot     = q_ff;
   assign quot_neg = neg_ff;

endmodule

@@ design/ami_datapath.sv @@
// ----------------------------------------------------------------------------
// ami_datapath
// Element store, shared multiplier, cofactor/determinant/translation
// accumulators, divider and the result output register.
// ----------------------------------------------------------------------------
module ami_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ami_pkg::cmd_type     cmd,
   input  logic signed [31:0]   req_element,
   output ami_pkg::sts_type     sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_element_out,
   output logic [3:0]           rsp_position,
   output logic                 rsp_singular,
   output logic                 rsp_saturated,
   output logic                 rsp_final_res
);

   logic [31:0]        store_ff [16];
   logic signed [64:0] cof_ff [9];
   logic [31:0]        res_ff [12];
   logic               rsat_ff [12];
   logic signed [32:0] opa_ff;
   logic signed [32:0] opb_ff;
   logic signed [65:0] prod_ff;
   logic signed [96:0] det_ff;
   logic signed [65:0] tacc_ff;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_element_ff;
   logic [3:0]         rsp_position_ff;
   logic               rsp_singular_ff;
   logic               rsp_saturated_ff;
   logic               rsp_final_ff;

   logic [31:0]        m_rd;
   logic signed [32:0] m_ext;
   logic signed [64:0] cof_rd;
   logic signed [65:0] prod_mul;
   logic signed [64:0] prod_cof;
   logic signed [96:0] det_add;
   logic [63:0]        cof_mag;
   logic [95:0]        det_mag;
   logic               singular;
   logic [65:0]        tacc_mag;
   logic [32:0]        trn_res;
   logic [32:0]        div_res;
   logic               out_free;
   logic [31:0]        emit_val;
   logic               emit_sat;

   logic               div_busy;
   logic               div_over;
   logic [31:0]        div_quot;
   logic               div_neg;

   always_comb begin
      m_rd     = store_ff[cmd.maddr];
      m_ext    = 33'(signed'(m_rd));
      cof_rd   = cof_ff[cmd.cidx];
      prod_mul = 66'(opa_ff) * 66'(opb_ff);
      prod_cof = cmd.neg ? -prod_ff[64:0] : prod_ff[64:0];
      det_add  = cmd.hi ? (97'(prod_ff) <<< 32) : 97'(prod_ff);
      cof_mag  = cof_rd[64] ? 64'(-cof_rd) : cof_rd[63:0];
      det_mag  = det_ff[96] ? 96'(-det_ff) : det_ff[95:0];
      singular = (det_ff == '0);
      tacc_mag = tacc_ff[65] ? 66'(-tacc_ff) : tacc_ff;
      trn_res  = ami_pkg::sat32(|tacc_mag[65:48], tacc_mag[47:16], tacc_ff[65]);
      div_res  = ami_pkg::sat32(div_over, div_quot, div_neg);
      out_free = !rsp_valid_ff || rsp_ready;
      emit_val = m_rd;
      emit_sat = 1'b0;
      if ((cmd.ridx < 4'd12) && !singular) begin
         emit_val = res_ff[cmd.ridx];
         emit_sat = rsat_ff[cmd.ridx];
      end else if (cmd.ridx < 4'd12) begin
         emit_val = '0;
      end
   end

   ami_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == ami_pkg::OP_DIV_START),
      .num_mag  (cof_mag),
      .den_mag  (det_mag),
      .neg      (cof_rd[64] ^ det_ff[96]),
      .busy     (div_busy),
      .over     (div_over),
      .quot     (div_quot),
      .quot_neg (div_neg)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         ami_pkg::OP_WRITE:     store_ff[cmd.maddr] <= req_element;
         ami_pkg::OP_LDA_M:     opa_ff <= m_ext;
         ami_pkg::OP_LDB_M:     opb_ff <= cmd.neg ? -m_ext : m_ext;
         ami_pkg::OP_LDA_COF:   opa_ff <= cmd.hi ? cof_rd[64:32] : {1'b0, cof_rd[31:0]};
         ami_pkg::OP_LDA_RES:   opa_ff <= 33'(signed'(res_ff[cmd.ridx]));
         ami_pkg::OP_MUL:       prod_ff <= prod_mul;
         ami_pkg::OP_ACC_COF:   cof_ff[cmd.cidx] <= (cmd.first ? '0 : cof_rd) + prod_cof;
         ami_pkg::OP_ACC_DET:   det_ff <= (cmd.first ? '0 : det_ff) + det_add;
         ami_pkg::OP_ACC_TRN:   tacc_ff <= (cmd.first ? '0 : tacc_ff) + prod_ff;
         ami_pkg::OP_TRN_STORE: begin
            res_ff[cmd.ridx]  <= trn_res[31:0];
            rsat_ff[cmd.ridx] <= trn_res[32];
         end
         ami_pkg::OP_DIV_STORE: begin
            res_ff[cmd.ridx]  <= div_res[31:0];
            rsat_ff[cmd.ridx] <= div_res[32];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == ami_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ami_pkg::OP_EMIT) begin
         rsp_element_ff   <= emit_val;
         rsp_position_ff  <= cmd.ridx;
         rsp_singular_ff  <= singular;
         rsp_saturated_ff <= emit_sat;
         rsp_final_ff     <= (cmd.ridx == 4'd15);
      end
   end

   assign sts.singular    = singular;
   assign sts.div_busy    = div_busy;
   assign sts.out_free    = out_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_element_out = signed'(rsp_element_ff);
   assign rsp_position    = rsp_position_ff;
   assign rsp_singular    = rsp_singular_ff;
   assign rsp_saturated   = rsp_saturated_ff;
   assign rsp_final_res   = rsp_final_ff;

endmodule

@@ design/ami_ctrl.sv @@
// ----------------------------------------------------------------------------
// ami_ctrl
// Sequencer that loads the matrix and steps the datapath through cofactors,
// determinant, divisions, translation and the output beats.
// ----------------------------------------------------------------------------
module ami_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ami_pkg::sts_type sts,
   output ami_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_LOAD = 8'b0000_0001,
      ST_COF  = 8'b0000_0010,
      ST_DET  = 8'b0000_0100,
      ST_CHK  = 8'b0000_1000,
      ST_DIV  = 8'b0001_0000,
      ST_TRN  = 8'b0010_0000,
      ST_TST  = 8'b0100_0000,
      ST_EMIT = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [4:0] idx_ff, idx_in;
   logic [1:0] stp_ff, stp_in;
   logic [1:0] sub_ff, sub_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      stp_in    = stp_ff + 2'd1;
      sub_in    = sub_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op    = ami_pkg::OP_NONE;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            stp_in    = '0;
            if (req_valid) begin
               cmd.op    = ami_pkg::OP_WRITE;
               cmd.maddr = cnt_ff;
               cnt_in    = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_in = ST_COF;
                  idx_in   = '0;
               end
            end
         end
         ST_COF: begin
            cmd.cidx = idx_ff[4:1];
            case (stp_ff)
               2'd0: begin
                  cmd.op    = ami_pkg::OP_LDA_M;
                  cmd.maddr = ami_pkg::cof_addr(idx_ff[4:1], idx_ff[0], 1'b0);
               end
               2'd1: begin
                  cmd.op    = ami_pkg::OP_LDB_M;
                  cmd.maddr = ami_pkg::cof_addr(idx_ff[4:1], idx_ff[0], 1'b1);
               end
               2'd2: cmd.op = ami_pkg::OP_MUL;
               default: begin
                  cmd.op    = ami_pkg::OP_ACC_COF;
                  cmd.first = !idx_ff[0];
                  cmd.neg   = idx_ff[0];
                  idx_in    = idx_ff + 5'd1;
                  if (idx_ff == 5'd17) begin
                     state_in = ST_DET;
                     idx_in   = '0;
                  end
               end
            endcase
         end
         ST_DET: begin
            cmd.cidx = {2'b00, idx_ff[2:1]};
            cmd.hi   = idx_ff[0];
            case (stp_ff)
               2'd0: cmd.op = ami_pkg::OP_LDA_COF;
               2'd1: begin
                  cmd.op    = ami_pkg::OP_LDB_M;
                  cmd.maddr = {idx_ff[2:1], 2'b00};
               end
               2'd2: cmd.op = ami_pkg::OP_MUL;
               default: begin
                  cmd.op    = ami_pkg::OP_ACC_DET;
                  cmd.first = (idx_ff == 5'd0);
                  idx_in    = idx_ff + 5'd1;
                  if (idx_ff == 5'd5) begin
                     state_in = ST_CHK;
                     idx_in   = '0;
                  end
               end
            endcase
         end
         ST_CHK: begin
            stp_in = '0;
            idx_in = '0;
            state_in = sts.singular ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            cmd.cidx = idx_ff[3:0];
            cmd.ridx = ami_pkg::blk_pos(idx_ff[3:0]);
            case (stp_ff)
               2'd0: begin
                  cmd.op = ami_pkg::OP_DIV_START;
                  stp_in = 2'd1;
               end
               2'd1: stp_in = sts.div_busy ? 2'd1 : 2'd2;
               default: begin
                  cmd.op = ami_pkg::OP_DIV_STORE;
                  stp_in = '0;
                  idx_in = idx_ff + 5'd1;
                  if (idx_ff == 5'd8) begin
                     state_in = ST_TRN;
                     idx_in   = '0;
                     sub_in   = '0;
                  end
               end
            endcase
         end
         ST_TRN: begin
            case (stp_ff)
               2'd0: begin
                  cmd.op   = ami_pkg::OP_LDA_RES;
                  cmd.ridx = {idx_ff[1:0], sub_ff};
               end
               2'd1: begin
                  cmd.op    = ami_pkg::OP_LDB_M;
                  cmd.maddr = {sub_ff, 2'b11};
                  cmd.neg   = 1'b1;
               end
               2'd2: cmd.op = ami_pkg::OP_MUL;
               default: begin
                  cmd.op    = ami_pkg::OP_ACC_TRN;
                  cmd.first = (sub_ff == 2'd0);
                  sub_in    = sub_ff + 2'd1;
                  if (sub_ff == 2'd2) begin
                     state_in = ST_TST;
                  end
               end
            endcase
         end
         ST_TST: begin
            cmd.op   = ami_pkg::OP_TRN_STORE;
            cmd.ridx = {idx_ff[1:0], 2'b11};
            stp_in   = '0;
            sub_in   = '0;
            idx_in   = idx_ff + 5'd1;
            state_in = ST_TRN;
            if (idx_ff == 5'd2) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            cmd.maddr = idx_ff[3:0];
            cmd.ridx  = idx_ff[3:0];
            stp_in    = '0;
            if (sts.out_free) begin
               cmd.op = ami_pkg::OP_EMIT;
               idx_in = idx_ff + 5'd1;
               if (idx_ff == 5'd15) begin
                  state_in = ST_LOAD;
                  idx_in   = '0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         stp_ff   <= '0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         stp_ff   <= stp_in;
         sub_ff   <= sub_in;
      end
   end

endmodule

@@ design/affine_matrix_inverse.sv @@
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverts a 4x4 affine matrix of signed Q16.16 elements.
//
// The req channel takes one element per beat in row-major order, one beat
// per cycle while loading. After the sixteenth beat the block stops taking
// elements, computes nine cofactors and the determinant on one shared
// multiplier, divides each cofactor by the determinant in a bit-serial
// divider, forms the translation and then sends sixteen beats on the rsp
// channel with position, singular, saturated and final_res flags.
// Most of the time between the last input beat and the first output beat
// goes to the nine divisions. A singular matrix skips division and
// translation. The output beats follow one per cycle when rsp_ready stays
// high; a stall holds the output register and the sequencer. Reset returns
// the block to loading element zero and drops rsp_valid.
// ----------------------------------------------------------------------------
module affine_matrix_inverse (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_element,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_element_out,
   output logic [3:0]         rsp_position,
   output logic               rsp_singular,
   output logic               rsp_saturated,
   output logic               rsp_final_res
);

   ami_pkg::cmd_type cmd;
   ami_pkg::sts_type sts;

   ami_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ami_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_element     (req_element),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_element_out (rsp_element_out),
      .rsp_position    (rsp_position),
      .rsp_singular    (rsp_singular),
      .rsp_saturated   (rsp_saturated),
      .rsp_final_res   (rsp_final_res)
   );

endmodule

@@ design/ami_checker.sv @@
// ----------------------------------------------------------------------------
// ami_checker
// Port-level checks on the result beats of the affine matrix inverse.
// ----------------------------------------------------------------------------
module ami_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_element_out,
   input logic [3:0]         rsp_position,
   input logic               rsp_singular,
   input logic               rsp_saturated,
   input logic               rsp_final_res
);

   // A stalled beat keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_out)
         && $stable(rsp_position))
      else $error("result beat changed while stalled");

   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_res == (rsp_position == 4'd15)))
      else $error("final flag does not match position");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_final_res) ##1 rsp_valid |->
         (rsp_position == 4'($past(rsp_position) + 4'd1))
         && (rsp_singular == $past(rsp_singular)))
      else $error("result beats out of order or singular flag changed");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_element_out == 32'sh7FFF_FFFF) || (rsp_element_out == -32'sh8000_0000))
      else $error("saturated beat is not at a range limit");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular && (rsp_position < 4'd12) |->
         (rsp_element_out == '0) && !rsp_saturated)
      else $error("singular matrix gave a nonzero block element");

endmodule

bind affine_matrix_inverse ami_checker u_ami_checker (.*);

@@ verif/tb_affine_matrix_inverse.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_matrix_inverse
// Sends whole 4x4 matrices to the affine matrix inverse block, one element
// per beat, and checks the sixteen result beats of each matrix against a
// behavioral inverse of the block. The beats are checked field by field, in
// order, under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_affine_matrix_inverse;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_element;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_element_out;
   logic [3:0]         rsp_position;
   logic               rsp_singular;
   logic               rsp_saturated;
   logic               rsp_final_res;

   typedef struct {
      logic [31:0] element;
      logic [3:0]  position;
      logic        singular;
      logic        saturated;
      logic        final_res;
   } beat_type;

   beat_type     inverse_q[$];
   logic [31:0]  loaded[16];
   int unsigned  load_idx;
   int unsigned  send_idle_pct;
   int unsigned  stall_pct;
   int unsigned  errors;
   longint       cycles;

   affine_matrix_inverse i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_element_out (rsp_element_out),
      .rsp_position    (rsp_position),
      .rsp_singular    (rsp_singular),
      .rsp_saturated   (rsp_saturated),
      .rsp_final_res   (rsp_final_res)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [31:0] clamp32(input logic signed [127:0] v,
                                           output logic sat);
      if (v > 128'sh7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -128'sh8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      sat = 1'b0;
      return v[31:0];
   endfunction

   // Division and shift truncate toward zero, as the block does.
   function automatic logic signed [127:0] quot0(input logic signed [127:0] n,
                                                 input logic signed [127:0] d);
      logic [127:0] na;
      logic [127:0] da;
      logic [127:0] q;
      na = n[127] ? -n : n;
      da = d[127] ? -d : d;
      q  = na / da;
      return (n[127] ^ d[127]) ? -$signed(q) : $signed(q);
   endfunction

   task automatic predict_inverse();
      logic signed [127:0] m[16];
      logic signed [127:0] cof[16];
      logic signed [127:0] det;
      logic signed [127:0] acc;
      logic signed [127:0] mag;
      logic [31:0]         res[16];
      logic                sat[16];
      logic                sing;
      beat_type            b;
      for (int i = 0; i < 16; i++) begin
         m[i]   = $signed(loaded[i]);
         cof[i] = 0;
         res[i] = '0;
         sat[i] = 1'b0;
      end
      cof[0]  = m[5] * m[10] - m[6] * m[9];
      cof[1]  = m[9] * m[2] - m[10] * m[1];
      cof[2]  = m[1] * m[6] - m[2] * m[5];
      cof[4]  = m[6] * m[8] - m[4] * m[10];
      cof[5]  = m[10] * m[0] - m[8] * m[2];
      cof[6]  = m[2] * m[4] - m[0] * m[6];
      cof[8]  = m[4] * m[9] - m[5] * m[8];
      cof[9]  = m[8] * m[1] - m[9] * m[0];
      cof[10] = m[0] * m[5] - m[1] * m[4];
      det  = m[0] * cof[0] + m[4] * cof[1] + m[8] * cof[2];
      sing = (det == 0);
      if (!sing) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               res[r*4+c] = clamp32(quot0(cof[r*4+c] <<< 32, det), sat[r*4+c]);
            end
         end
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
               acc += 128'($signed(res[r*4+c])) * (-m[c*4+3]);
            end
            mag = acc[127] ? -acc : acc;
            mag = mag >>> 16;
            if (acc[127]) mag = -mag;
            res[r*4+3] = clamp32(mag, sat[r*4+3]);
         end
      end
      for (int i = 12; i < 16; i++) res[i] = loaded[i];
      for (int i = 0; i < 16; i++) begin
         b.element   = res[i];
         b.position  = 4'(i);
         b.singular  = sing;
         b.saturated = sat[i];
         b.final_res = (i == 15);
         inverse_q.push_back(b);
      end
   endtask

   task automatic send_element(input logic [31:0] value);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_element <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      loaded[load_idx] = value;
      if (load_idx == 15) begin
         load_idx = 0;
         predict_inverse();
      end else begin
         load_idx++;
      end
      if (send_idle_pct != 0 || $urandom_range(3) == 0) begin
         req_valid   <= 1'b0;
         req_element <= $urandom;
         @(posedge clock);
      end
   endtask

   task automatic send_matrix(input logic [31:0] mat[16]);
      for (int i = 0; i < 16; i++) send_element(mat[i]);
   endtask

   function automatic logic [31:0] rand_element(input int unsigned kind);
      case (kind)
         0:       return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         1:       return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
         2:       return $urandom;
         default: return ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      endcase
   endfunction

   task automatic make_matrix(output logic [31:0] mat[16], input int unsigned kind);
      for (int i = 0; i < 16; i++) mat[i] = rand_element(kind);
      if (kind == 0 && $urandom_range(4) == 0) begin
         for (int c = 0; c < 3; c++) mat[8+c] = mat[c];
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (inverse_q.size() == 0) begin
               $error("result beat with no expectation, element %h", rsp_element_out);
               errors++;
            end else begin
               beat_type b;
               b = inverse_q.pop_front();
               if (rsp_element_out !== b.element) begin
                  $error("element_out: expected %h actual %h", b.element, rsp_element_out);
                  errors++;
               end
               if (rsp_position !== b.position) begin
                  $error("position: expected %0d actual %0d", b.position, rsp_position);
                  errors++;
               end
               if (rsp_singular !== b.singular) begin
                  $error("singular: expected %b actual %b", b.singular, rsp_singular);
                  errors++;
               end
               if (rsp_saturated !== b.saturated) begin
                  $error("saturated: expected %b actual %b", b.saturated, rsp_saturated);
                  errors++;
               end
               if (rsp_final_res !== b.final_res) begin
                  $error("final_res: expected %b actual %b", b.final_res, rsp_final_res);
                  errors++;
               end
            end
         end
         rsp_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
      end
      if (cycles > 400000) begin
         $display("tb_affine_matrix_inverse: done, errors");
         $finish;
      end
   end

   task automatic drain();
      req_valid <= 1'b0;
      while (inverse_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [31:0] mat[16];
      // An identity block with a translation gives an exact inverse.
      foreach (mat[i]) mat[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
      mat[3] = 32'h0002_0000;
      mat[7] = 32'hFFFF_0000;
      send_matrix(mat);
      // All zeros but the last element is singular.
      foreach (mat[i]) mat[i] = 32'h0;
      mat[15] = 32'hFFFF_FFFF;
      send_matrix(mat);
      // A tiny diagonal saturates the inverse and the translation.
      foreach (mat[i]) mat[i] = (i % 5 == 0) ? 32'h0000_0001 : 32'h0;
      mat[3]  = 32'h7FFF_FFFF;
      mat[7]  = 32'h8000_0000;
      mat[11] = 32'h8000_0000;
      mat[12] = 32'h8000_0000;
      mat[13] = 32'h7FFF_FFFF;
      send_matrix(mat);
      // Extremes everywhere.
      foreach (mat[i]) mat[i] = (i % 3 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      send_matrix(mat);
      drain();
   endtask

   task automatic test_random(input int unsigned count, input int unsigned idle,
                              input int unsigned stall);
      logic [31:0] mat[16];
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int n = 0; n < count; n++) begin
         make_matrix(mat, $urandom_range(3));
         send_matrix(mat);
      end
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_element   = '0;
      rsp_ready     = 1'b0;
      errors        = 0;
      cycles        = 0;
      load_idx      = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1, 62, 0);
      test_random(1, 0, 62);
      test_random(1, 7, 7);
      req_valid <= 1'b0;
      repeat (50) @(posedge clock);
      if (errors == 0 && inverse_q.size() == 0) begin
         $display("tb_affine_matrix_inverse: done, clean");
      end else begin
         $display("tb_affine_matrix_inverse: done, errors");
      end
      $finish;
   end

endmodule
